### rtl/fqds_pkg.sv
// Shared widths, reset values and the result record of the queue delay statistics block.
// Has no dependencies; every other file in rtl imports it.
package fqds_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int SUM_WIDTH  = 48;
    localparam int CNT_WIDTH  = 32;
    localparam int OBS_WIDTH  = 32;

    // 400.0 in Q24.8.
    localparam logic [OBS_WIDTH-1:0] OBSERVE_RESET = OBS_WIDTH'(102400);

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [SUM_WIDTH-1:0]  sum_t;
    typedef logic [CNT_WIDTH-1:0]  cnt_t;

    // One result item; the running fields double as the block's statistics state.
    typedef struct packed {
        time_t job_delay;
        time_t job_wait;
        time_t job_departure;
        logic  was_delayed;
        cnt_t  jobs_seen;
        cnt_t  jobs_undelayed;
        cnt_t  jobs_at_observe;
        time_t greatest_delay;
        sum_t  total_delay;
        sum_t  total_wait;
        sum_t  total_service;
    } fqds_result_t;

endpackage

### rtl/fqds_in_stage.sv
// Input register of the queue delay statistics block: captures one job per cycle while it is empty or its job moves on.
// Depends on fqds_pkg.
module fqds_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fqds_pkg::time_t       s_arrival_time,
    input  fqds_pkg::time_t       s_service_time,
    input  logic                  advance,
    output logic                  job_valid,
    output fqds_pkg::time_t       job_arrival,
    output fqds_pkg::time_t       job_service
);
    import fqds_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    time_t arrival_reg;
    time_t service_reg;
    logic  load;

    // The stage frees up in the same cycle that its item moves on.
    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            arrival_reg <= s_arrival_time;
            service_reg <= s_service_time;
        end
    end

    assign job_valid   = valid_reg;
    assign job_arrival = arrival_reg;
    assign job_service = service_reg;

endmodule

### rtl/fqds_update.sv
// Next-state logic of the queue delay statistics: one Lindley step plus the running statistics.
// Depends on fqds_pkg.
module fqds_update (
    input  fqds_pkg::time_t          arrival,
    input  fqds_pkg::time_t          service,
    input  logic [fqds_pkg::OBS_WIDTH-1:0] observe_time,
    input  fqds_pkg::fqds_result_t   prev,
    output fqds_pkg::fqds_result_t   next
);
    import fqds_pkg::*;

    localparam time_t TIME_MAX = '1;
    localparam sum_t  SUM_MAX  = '1;
    localparam cnt_t  CNT_MAX  = '1;

    logic                  delayed;
    time_t                 delay;
    time_t                 start;
    logic [TIME_WIDTH:0]   wait_ext;
    logic [TIME_WIDTH:0]   dep_ext;
    time_t                 wait_sat;
    time_t                 dep_sat;
    logic [SUM_WIDTH:0]    dsum_ext;
    logic [SUM_WIDTH:0]    wsum_ext;
    logic [SUM_WIDTH:0]    ssum_ext;
    logic                  straddle;

    assign delayed = arrival < prev.job_departure;
    assign delay   = delayed ? (prev.job_departure - arrival) : '0;

    // Departure equals the later of arrival and last departure plus service,
    // saturated; this matches arrival plus the saturated wait in every case and
    // keeps the departure path to one add.
    assign start    = delayed ? prev.job_departure : arrival;
    assign wait_ext = {1'b0, delay} + {1'b0, service};
    assign dep_ext  = {1'b0, start} + {1'b0, service};
    assign wait_sat = wait_ext[TIME_WIDTH] ? TIME_MAX : wait_ext[TIME_WIDTH-1:0];
    assign dep_sat  = dep_ext[TIME_WIDTH]  ? TIME_MAX : dep_ext[TIME_WIDTH-1:0];

    assign straddle = (TIME_WIDTH'(dep_sat) > observe_time) && (arrival < observe_time);

    assign dsum_ext = {1'b0, prev.total_delay}   + (SUM_WIDTH + 1)'(delay);
    assign wsum_ext = {1'b0, prev.total_wait}    + (SUM_WIDTH + 1)'(wait_sat);
    assign ssum_ext = {1'b0, prev.total_service} + (SUM_WIDTH + 1)'(service);

    always_comb begin
        next.job_delay      = delay;
        next.job_wait       = wait_sat;
        next.job_departure  = dep_sat;
        next.was_delayed    = delayed;
        next.jobs_seen      = (prev.jobs_seen == CNT_MAX) ? CNT_MAX
                                                         : prev.jobs_seen + cnt_t'(1);
        next.jobs_undelayed = prev.jobs_undelayed;
        if (!delayed && prev.jobs_undelayed != CNT_MAX) begin
            next.jobs_undelayed = prev.jobs_undelayed + cnt_t'(1);
        end
        next.jobs_at_observe = prev.jobs_at_observe;
        if (straddle && prev.jobs_at_observe != CNT_MAX) begin
            next.jobs_at_observe = prev.jobs_at_observe + cnt_t'(1);
        end
        next.greatest_delay = (delayed && delay > prev.greatest_delay) ? delay
                                                                       : prev.greatest_delay;
        next.total_delay   = dsum_ext[SUM_WIDTH] ? SUM_MAX : dsum_ext[SUM_WIDTH-1:0];
        next.total_wait    = wsum_ext[SUM_WIDTH] ? SUM_MAX : wsum_ext[SUM_WIDTH-1:0];
        next.total_service = ssum_ext[SUM_WIDTH] ? SUM_MAX : ssum_ext[SUM_WIDTH-1:0];
    end

endmodule

### rtl/fifo_queue_delay_statistics.sv
// Top level of the single-server FIFO queue delay statistics block.
// Depends on fqds_pkg, fqds_in_stage and fqds_update.
//
// Each accepted item is one job (arrival and service time, Q24.8) and yields one
// result item with its delay, wait and departure plus the running counts, the
// greatest delay and the saturating sums, all as they stand after that job.
// The block takes one job per clock cycle while the result side does not stall; a job
// waits in the input register and its result is loaded into the result register. While
// the result side stalls, the block holds one result and one waiting job and then stops
// accepting. The rate is set by the departure-time register, which is read and rewritten
// by a single compare and add for every job. The user must write observe_time through
// cfg_wr_en/cfg_wr_data only while no job is in flight; the block does not enforce this.
module fifo_queue_delay_statistics (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fqds_pkg::OBS_WIDTH-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fqds_pkg::time_t                     s_arrival_time,
    input  fqds_pkg::time_t                     s_service_time,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fqds_pkg::time_t                     m_job_delay,
    output fqds_pkg::time_t                     m_job_wait,
    output fqds_pkg::time_t                     m_job_departure,
    output logic                                m_was_delayed,
    output fqds_pkg::cnt_t                      m_jobs_seen,
    output fqds_pkg::cnt_t                      m_jobs_undelayed,
    output fqds_pkg::cnt_t                      m_jobs_at_observe,
    output fqds_pkg::time_t                     m_greatest_delay,
    output fqds_pkg::sum_t                      m_total_delay,
    output fqds_pkg::sum_t                      m_total_wait,
    output fqds_pkg::sum_t                      m_total_service
);
    import fqds_pkg::*;

    logic                  job_valid;
    time_t                 job_arrival;
    time_t                 job_service;
    logic                  advance;
    logic [OBS_WIDTH-1:0]  observe_reg;
    fqds_result_t          result_reg;
    fqds_result_t          result_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;

    assign advance = job_valid && (!m_valid_reg || m_ready);

    fqds_in_stage u_in_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_arrival_time (s_arrival_time),
        .s_service_time (s_service_time),
        .advance        (advance),
        .job_valid      (job_valid),
        .job_arrival    (job_arrival),
        .job_service    (job_service)
    );

    fqds_update u_update (
        .arrival      (job_arrival),
        .service      (job_service),
        .observe_time (observe_reg),
        .prev         (result_reg),
        .next         (result_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // The result register also holds the statistics state, so it is reset to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            observe_reg <= OBSERVE_RESET;
            result_reg  <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                observe_reg <= cfg_wr_data;
            end
            if (advance) begin
                result_reg <= result_next;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_job_delay       = result_reg.job_delay;
    assign m_job_wait        = result_reg.job_wait;
    assign m_job_departure   = result_reg.job_departure;
    assign m_was_delayed     = result_reg.was_delayed;
    assign m_jobs_seen       = result_reg.jobs_seen;
    assign m_jobs_undelayed  = result_reg.jobs_undelayed;
    assign m_jobs_at_observe = result_reg.jobs_at_observe;
    assign m_greatest_delay  = result_reg.greatest_delay;
    assign m_total_delay     = result_reg.total_delay;
    assign m_total_wait      = result_reg.total_wait;
    assign m_total_service   = result_reg.total_service;

endmodule

### rtl/fqds_checker.sv
// Port-level checks for fifo_queue_delay_statistics, bound to the top level below.
// Depends on fqds_pkg and the top level.
module fqds_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  fqds_pkg::time_t                     m_job_delay,
    input  fqds_pkg::time_t                     m_job_wait,
    input  fqds_pkg::time_t                     m_job_departure,
    input  logic                                m_was_delayed,
    input  fqds_pkg::cnt_t                      m_jobs_seen,
    input  fqds_pkg::cnt_t                      m_jobs_undelayed,
    input  fqds_pkg::time_t                     m_greatest_delay
);
    import fqds_pkg::*;

    // A stalled result item keeps its valid and its departure time.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_job_departure))
        else $error("result item changed while stalled");

    // No result item is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A delayed job always has a nonzero delay, an undelayed one none.
    a_delay_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_was_delayed == (m_job_delay != '0)))
        else $error("delay flag disagrees with delay");

    // Greatest delay >= delay, undelayed <= seen, and delay <= wait <= departure.
    a_stat_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_greatest_delay >= m_job_delay) && (m_jobs_undelayed <= m_jobs_seen)
                    && (m_job_wait >= m_job_delay) && (m_job_departure >= m_job_wait))
        else $error("running statistics out of bounds");

endmodule

bind fifo_queue_delay_statistics fqds_checker u_fqds_checker (.*);
